[hw/rtl/hsr_pkg.sv]
// Shared types, constants and helper functions for the H-bridge speed ramp.
// No dependencies; imported by every other file of the block.
package hsr_pkg;

    localparam int SPEED_W    = 8;
    localparam int INTERVAL_W = 16;

    localparam int STEP_SIZE    = 4;
    localparam int STOP_DIVISOR = 5;

    // Divide-by-constant via reciprocal multiply; exact over the full
    // 16-bit interval range for any divisor up to 16.
    localparam int STOP_SHIFT  = 20;
    localparam int STOP_RECIP  = ((1 << STOP_SHIFT) + STOP_DIVISOR - 1) / STOP_DIVISOR;
    localparam int RECIP_W     = STOP_SHIFT + 1;
    localparam int PRODUCT_W   = INTERVAL_W + RECIP_W;

    localparam logic [INTERVAL_W-1:0] RAMP_INTERVAL_RESET = INTERVAL_W'(5);
    localparam logic [INTERVAL_W-1:0] FAST_PERIOD_RESET   =
        INTERVAL_W'(5 / STOP_DIVISOR);

    localparam logic [SPEED_W-1:0] STEP_AMOUNT = SPEED_W'(STEP_SIZE);

    typedef enum logic [1:0] {
        OP_SET_TARGET  = 2'd0,
        OP_TICK        = 2'd1,
        OP_SMOOTH_STOP = 2'd2,
        OP_HARD_STOP   = 2'd3
    } hsr_op_t;

    typedef struct packed {
        hsr_op_t              op;
        logic                 target_direction;
        logic [SPEED_W-1:0]   target_speed;
    } hsr_cmd_t;

    typedef struct packed {
        logic [SPEED_W-1:0]   forward_duty;
        logic [SPEED_W-1:0]   backward_duty;
        logic                 current_direction;
        logic                 settled;
    } hsr_result_t;

    typedef struct packed {
        logic [SPEED_W-1:0]    present_speed;
        logic                  present_direction;
        logic [SPEED_W-1:0]    goal_speed;
        logic                  goal_direction;
        logic [INTERVAL_W-1:0] interval_counter;
        logic                  fast_stop_mode;
    } hsr_state_t;

    // One step toward the goal, clamped so it never overshoots.
    function automatic logic [SPEED_W-1:0] move_toward(
        input logic [SPEED_W-1:0] from,
        input logic [SPEED_W-1:0] to
    );
        logic [SPEED_W-1:0] result;
        result = from;
        if (from < to)
        begin
            result = ((to - from) > STEP_AMOUNT) ? from + STEP_AMOUNT : to;
        end
        else if (from > to)
        begin
            result = ((from - to) > STEP_AMOUNT) ? from - STEP_AMOUNT : to;
        end
        return result;
    endfunction

    // Interval divided by STOP_DIVISOR.
    function automatic logic [INTERVAL_W-1:0] stop_period(
        input logic [INTERVAL_W-1:0] interval
    );
        logic [PRODUCT_W-1:0] product;
        product = PRODUCT_W'(interval) * PRODUCT_W'(STOP_RECIP);
        return product[STOP_SHIFT +: INTERVAL_W];
    endfunction

endpackage

[hw/rtl/hsr_cmd_if.sv]
// Command channel: valid/ready handshake carrying one ramp command.
// Depends on hsr_pkg for field types.
interface hsr_cmd_if;
    logic                         valid;
    logic                         ready;
    hsr_pkg::hsr_op_t             op;
    logic                         target_direction;
    logic [hsr_pkg::SPEED_W-1:0]  target_speed;

    modport source (output valid, output op, output target_direction,
                    output target_speed, input ready);
    modport sink   (input valid, input op, input target_direction,
                    input target_speed, output ready);
endinterface

[hw/rtl/hsr_res_if.sv]
// Result channel: valid/ready handshake carrying bridge duties and status.
// Depends on hsr_pkg for field widths.
interface hsr_res_if;
    logic                         valid;
    logic                         ready;
    logic [hsr_pkg::SPEED_W-1:0]  forward_duty;
    logic [hsr_pkg::SPEED_W-1:0]  backward_duty;
    logic                         current_direction;
    logic                         settled;

    modport source (output valid, output forward_duty, output backward_duty,
                    output current_direction, output settled, input ready);
    modport sink   (input valid, input forward_duty, input backward_duty,
                    input current_direction, input settled, output ready);
endinterface

[hw/rtl/hsr_step.sv]
// Next-state and result logic for one command of the speed ramp.
// Depends on hsr_pkg.
module hsr_step (
    input  hsr_pkg::hsr_cmd_t                  cmd,
    input  hsr_pkg::hsr_state_t                state,
    input  logic [hsr_pkg::INTERVAL_W-1:0]     ramp_interval,
    input  logic [hsr_pkg::INTERVAL_W-1:0]     fast_period,
    output hsr_pkg::hsr_state_t                state_next,
    output hsr_pkg::hsr_result_t               result
);
    import hsr_pkg::*;

    logic [INTERVAL_W:0]   count_inc;
    logic [INTERVAL_W-1:0] period;
    hsr_state_t            stepped;

    assign count_inc = {1'b0, state.interval_counter} + (INTERVAL_W+1)'(1);
    assign period    = state.fast_stop_mode ? fast_period : ramp_interval;

    // One ramp step; reversal ramps down first, then flips and climbs.
    always_comb
    begin
        stepped = state;
        stepped.interval_counter = '0;
        if (state.present_direction != state.goal_direction &&
            state.present_speed != '0)
        begin
            stepped.present_speed = move_toward(state.present_speed, '0);
        end
        else
        begin
            stepped.present_direction = state.goal_direction;
            stepped.present_speed = move_toward(state.present_speed, state.goal_speed);
        end
    end

    always_comb
    begin
        state_next = state;
        case (cmd.op)
            OP_SET_TARGET:
            begin
                state_next.goal_speed       = cmd.target_speed;
                state_next.goal_direction   = cmd.target_direction;
                state_next.fast_stop_mode   = 1'b0;
                state_next.interval_counter = '0;
            end
            OP_TICK:
            begin
                if (count_inc >= {1'b0, period})
                begin
                    state_next = stepped;
                end
                else
                begin
                    state_next.interval_counter = count_inc[INTERVAL_W-1:0];
                end
            end
            OP_SMOOTH_STOP:
            begin
                state_next.goal_speed       = '0;
                state_next.goal_direction   = state.present_direction;
                state_next.fast_stop_mode   = 1'b1;
                state_next.interval_counter = '0;
            end
            OP_HARD_STOP:
            begin
                state_next.present_speed    = '0;
                state_next.goal_speed       = '0;
                state_next.goal_direction   = state.present_direction;
                state_next.fast_stop_mode   = 1'b0;
                state_next.interval_counter = '0;
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

    always_comb
    begin
        result.forward_duty      = state_next.present_direction ? state_next.present_speed : '0;
        result.backward_duty     = state_next.present_direction ? '0 : state_next.present_speed;
        result.current_direction = state_next.present_direction;
        result.settled           = (state_next.present_speed == state_next.goal_speed) &&
                                   (state_next.present_direction == state_next.goal_direction);
    end

endmodule

[hw/rtl/hbridge_speed_ramp.sv]
// Top level of the H-bridge speed ramp generator.
// Depends on hsr_pkg, hsr_cmd_if, hsr_res_if and hsr_step.
//
// Ramps an H-bridge PWM duty toward a commanded speed and direction. Every
// command transaction (set target, time tick, smooth stop, hard stop)
// produces exactly one result transaction holding the forward and backward
// duties, the driven direction and a settled flag, all taken after the
// update. Throughput is one command per clock while res.ready stays high;
// an accepted command is held in the command register, then its result
// is held in the result register. The ramp state lives in a
// single register set that the command register feeds through one pass of
// add/compare/clamp logic, so consecutive commands never wait on each
// other. A full result register stalls the command side only when the
// downstream holds ready low. ramp_interval (reset 5) is written through
// cfg_wr_en/cfg_wr_data while the block is idle, a rule for the user that
// the block does not enforce. The smooth-stop period (interval / 5) is
// computed at write time by a reciprocal multiply, kept in its own register.
module hbridge_speed_ramp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [hsr_pkg::INTERVAL_W-1:0] cfg_wr_data,
    hsr_cmd_if.sink                        cmd,
    hsr_res_if.source                      res
);
    import hsr_pkg::*;

    // configuration
    logic [INTERVAL_W-1:0] ramp_interval_reg;
    logic [INTERVAL_W-1:0] fast_period_reg;

    // command stage
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    hsr_cmd_t              s1_cmd_reg;
    hsr_cmd_t              cmd_in;

    // ramp state
    hsr_state_t            state_reg;
    hsr_state_t            state_next;

    // result stage
    logic                  out_valid_reg;
    logic                  out_valid_next;
    hsr_result_t           out_data_reg;
    hsr_result_t           step_result;

    logic                  cmd_take;
    logic                  advance;

    // The command stage moves on when the result slot is free or draining.
    assign advance   = s1_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !s1_valid_reg || advance;
    assign cmd_take  = cmd.valid && cmd.ready;

    assign cmd_in.op               = cmd.op;
    assign cmd_in.target_direction = cmd.target_direction;
    assign cmd_in.target_speed     = cmd.target_speed;

    always_comb
    begin
        s1_valid_next = cmd_take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    hsr_step u_step (
        .cmd           (s1_cmd_reg),
        .state         (state_reg),
        .ramp_interval (ramp_interval_reg),
        .fast_period   (fast_period_reg),
        .state_next    (state_next),
        .result        (step_result)
    );

    // Configuration; smooth-stop period derived at write time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_interval_reg <= RAMP_INTERVAL_RESET;
            fast_period_reg   <= FAST_PERIOD_RESET;
        end
        else if (cfg_wr_en)
        begin
            ramp_interval_reg <= cfg_wr_data;
            fast_period_reg   <= stop_period(cfg_wr_data);
        end
    end

    // Control and ramp state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg.present_speed     <= '0;
            state_reg.present_direction <= 1'b1;
            state_reg.goal_speed        <= '0;
            state_reg.goal_direction    <= 1'b1;
            state_reg.interval_counter  <= '0;
            state_reg.fast_stop_mode    <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            s1_cmd_reg <= cmd_in;
        end
        if (advance)
        begin
            out_data_reg <= step_result;
        end
    end

    assign res.valid             = out_valid_reg;
    assign res.forward_duty      = out_data_reg.forward_duty;
    assign res.backward_duty     = out_data_reg.backward_duty;
    assign res.current_direction = out_data_reg.current_direction;
    assign res.settled           = out_data_reg.settled;

endmodule

[sim/hsr_ramp_checker.sv]
// Checker for the H-bridge speed ramp: tracks the ramp state from the command
// transactions and compares every result transaction field by field.
// Depends on hsr_pkg, hsr_cmd_if and hsr_res_if.
module hsr_ramp_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [hsr_pkg::INTERVAL_W-1:0] cfg_wr_data,
    hsr_cmd_if                             cmd,
    hsr_res_if                             res,
    output int                             mismatches,
    output int                             in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    import hsr_pkg::*;

    logic [INTERVAL_W-1:0] interval_reg;
    logic [SPEED_W-1:0]    speed_now;
    logic                  dir_now;
    logic [SPEED_W-1:0]    speed_goal;
    logic                  dir_goal;
    logic [INTERVAL_W-1:0] tick_count;
    logic                  quick_stop;

    hsr_result_t pending_duties[$];
    int          fail_tally = 0;
    int          duties_owed = 0;

    assign mismatches = fail_tally;
    assign in_flight  = duties_owed;

    // One clamped step of STEP_SIZE toward the goal.
    function automatic logic [SPEED_W-1:0] nudge_speed(
        input logic [SPEED_W-1:0] from,
        input logic [SPEED_W-1:0] to
    );
        int gap;
        gap = int'(to) - int'(from);
        if (gap > STEP_SIZE)
        begin
            return from + SPEED_W'(STEP_SIZE);
        end
        if (gap < -STEP_SIZE)
        begin
            return from - SPEED_W'(STEP_SIZE);
        end
        return to;
    endfunction

    // Reversal: ramp down to zero first, then flip and ramp up in the same step.
    function automatic void advance_speed();
        if (dir_now != dir_goal)
        begin
            if (speed_now != '0)
            begin
                speed_now = nudge_speed(speed_now, '0);
                return;
            end
            dir_now = dir_goal;
        end
        speed_now = nudge_speed(speed_now, speed_goal);
    endfunction

    function automatic hsr_result_t ramp_update(
        input hsr_op_t            op,
        input logic               dir,
        input logic [SPEED_W-1:0] spd
    );
        logic [INTERVAL_W:0]   next_count;
        logic [INTERVAL_W-1:0] period;
        hsr_result_t           duties;
        case (op)
            OP_SET_TARGET:
            begin
                speed_goal = spd;
                dir_goal   = dir;
                quick_stop = 1'b0;
                tick_count = '0;
            end
            OP_TICK:
            begin
                period = quick_stop ? interval_reg / INTERVAL_W'(STOP_DIVISOR) : interval_reg;
                next_count = {1'b0, tick_count} + (INTERVAL_W+1)'(1);
                if (next_count >= {1'b0, period})
                begin
                    tick_count = '0;
                    advance_speed();
                end
                else
                begin
                    tick_count = next_count[INTERVAL_W-1:0];
                end
            end
            OP_SMOOTH_STOP:
            begin
                speed_goal = '0;
                dir_goal   = dir_now;
                quick_stop = 1'b1;
                tick_count = '0;
            end
            default:
            begin
                speed_now  = '0;
                speed_goal = '0;
                dir_goal   = dir_now;
                quick_stop = 1'b0;
                tick_count = '0;
            end
        endcase
        duties.forward_duty      = dir_now ? speed_now : '0;
        duties.backward_duty     = dir_now ? '0 : speed_now;
        duties.current_direction = dir_now;
        duties.settled           = (speed_now == speed_goal) && (dir_now == dir_goal);
        return duties;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_tally++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hsr_result_t want;
        if (!rst_n)
        begin
            interval_reg = RAMP_INTERVAL_RESET;
            speed_now    = '0;
            dir_now      = 1'b1;
            speed_goal   = '0;
            dir_goal     = 1'b1;
            tick_count   = '0;
            quick_stop   = 1'b0;
            pending_duties.delete();
            duties_owed  = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                interval_reg = cfg_wr_data;
            end
            if (cmd.valid && cmd.ready)
            begin
                pending_duties.push_back(
                    ramp_update(cmd.op, cmd.target_direction, cmd.target_speed));
            end
            if (res.valid && res.ready)
            begin
                if (pending_duties.size() == 0)
                begin
                    $error("result transaction with nothing outstanding");
                    fail_tally++;
                end
                else
                begin
                    want = pending_duties.pop_front();
                    check_field("forward_duty", int'(want.forward_duty),
                                int'(res.forward_duty));
                    check_field("backward_duty", int'(want.backward_duty),
                                int'(res.backward_duty));
                    check_field("current_direction", int'(want.current_direction),
                                int'(res.current_direction));
                    check_field("settled", int'(want.settled), int'(res.settled));
                end
            end
            duties_owed = pending_duties.size();
        end
    end

endmodule

[sim/tb_top.sv]
// Top of the H-bridge speed ramp testbench: clock, reset, command and
// config stimulus, result-side backpressure and the verdict.
// Depends on hsr_pkg, hsr_cmd_if, hsr_res_if, hsr_ramp_checker and the RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hsr_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en;
    logic [INTERVAL_W-1:0] cfg_wr_data;

    hsr_cmd_if cmd_ch();
    hsr_res_if res_ch();

    int mismatches;
    int in_flight;

    // Counted when a command is seen committed (sampled at negedge), so the
    // receiver process can read it at posedge without a race.
    int cmds_offered = 0;
    int burst_left = 0;

    // Ramp interval settings, one per random phase. Full-scale value is
    // followed by a small one so the counter sits above the new period and
    // the next tick has to step immediately.
    localparam int NUM_PHASES = 9;
    localparam logic [INTERVAL_W-1:0] PHASE_INTERVAL [NUM_PHASES] = '{
        16'd0, 16'd1, 16'hFFFF, 16'd3, 16'd2, 16'd0, 16'd7, 16'd1, 16'd4
    };
    localparam int PHASE_ITEMS = 142;

    // 12 ns clock
    always #6 clk = ~clk;

    hbridge_speed_ramp dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd_ch),
        .res         (res_ch)
    );

    hsr_ramp_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd_ch),
        .res         (res_ch),
        .mismatches  (mismatches),
        .in_flight   (in_flight)
    );

    // Reset: asserted from time zero, released once.
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Hard limit on the run.
    initial
    begin
        #5_000_000;
        $display("[hbridge_speed_ramp] ERROR");
        $finish;
    end

    // Offer one command transaction. Must be called right after a posedge.
    // Bursts of random length; between bursts valid drops for a random gap.
    // Roughly one burst in six is long so there are stretches with no idling.
    task automatic push_cmd(
        input hsr_op_t            op,
        input logic               dir,
        input logic [SPEED_W-1:0] spd
    );
        logic taken;
        if (burst_left == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 24);
        end
        cmd_ch.valid            <= 1'b1;
        cmd_ch.op               <= op;
        cmd_ch.target_direction <= dir;
        cmd_ch.target_speed     <= spd;
        taken = 1'b0;
        while (!taken)
        begin
            // inputs only change at posedge, so ready at negedge is what
            // the next posedge will see
            @(negedge clk);
            taken = cmd_ch.ready;
            if (taken)
            begin
                cmds_offered++;
            end
            @(posedge clk);
        end
        burst_left--;
    endtask

    // Time ticks carry don't-care direction/speed; randomize them anyway.
    task automatic tick_run(input int count);
        repeat (count)
        begin
            push_cmd(OP_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
    endtask

    // Stop offering and wait until every result transaction is back.
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        burst_left = 0;
        do
        begin
            @(negedge clk);
        end
        while (in_flight != 0);
        repeat (4) @(posedge clk);
    endtask

    // Block is idle here; one-cycle write strobe.
    task automatic write_interval(input logic [INTERVAL_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly well-formed sequences: a command followed by a run of ticks long
    // enough to ramp a good way, plus some raw noise transactions.
    task automatic random_phase(input int n_items);
        int made;
        int pick;
        int ticks;
        logic [SPEED_W-1:0] spd;
        made = 0;
        while (made < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                case ($urandom_range(0, 5))
                    0:       spd = '0;
                    1:       spd = '1;
                    default: spd = 8'($urandom_range(0, 255));
                endcase
                push_cmd(OP_SET_TARGET, 1'($urandom_range(0, 1)), spd);
                ticks = $urandom_range(1, 70);
            end
            else if (pick < 80)
            begin
                push_cmd(OP_SMOOTH_STOP, 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)));
                ticks = $urandom_range(1, 30);
            end
            else if (pick < 88)
            begin
                push_cmd(OP_HARD_STOP, 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)));
                ticks = $urandom_range(0, 5);
            end
            else
            begin
                push_cmd(hsr_op_t'($urandom_range(OP_SET_TARGET, OP_HARD_STOP)),
                         1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                ticks = 0;
            end
            tick_run(ticks);
            made += 1 + ticks;
        end
    endtask

    // Result side: ready high for random runs with short stalls between,
    // occasionally a long all-ready run. Once, mid-test, ready is held low while
    // commands keep coming, so the pipeline fills and cmd.ready has to drop.
    initial
    begin
        int run_len;
        int stall_len;
        bit long_hold_done;
        long_hold_done = 1'b0;
        res_ch.ready <= 1'b0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (!long_hold_done && cmds_offered >= 550)
            begin
                long_hold_done = 1'b1;
                repeat (250)
                begin
                    @(posedge clk);
                    res_ch.ready <= 1'b0;
                end
            end
            run_len = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 16);
            repeat (run_len)
            begin
                @(posedge clk);
                res_ch.ready <= 1'b1;
            end
            stall_len = $urandom_range(0, 5);
            repeat (stall_len)
            begin
                @(posedge clk);
                res_ch.ready <= 1'b0;
            end
        end
    end

    // Command and config stimulus, then the verdict.
    initial
    begin
        cmd_ch.valid            <= 1'b0;
        cmd_ch.op               <= OP_TICK;
        cmd_ch.target_direction <= 1'b0;
        cmd_ch.target_speed     <= '0;
        cfg_wr_en               <= 1'b0;
        cfg_wr_data             <= '0;
        while (!rst_n) @(posedge clk);
        @(posedge clk);

        // Directed part at the reset interval of 5 ticks per step.
        tick_run(1);                            // settled straight out of reset
        push_cmd(OP_SET_TARGET, 1'b1, 8'd255);  // full forward target
        tick_run(5);                            // one step up to 4
        push_cmd(OP_SET_TARGET, 1'b0, 8'd6);    // reversal request
        tick_run(5);                            // ramp down to zero, still forward
        tick_run(5);                            // flip to backward and step up
        push_cmd(OP_SMOOTH_STOP, 1'b1, 8'd0);   // smooth stop, period 5/5 = 1
        tick_run(1);                            // reaches zero in one tick
        push_cmd(OP_SET_TARGET, 1'b1, 8'd0);    // zero speed, other direction
        tick_run(1);
        push_cmd(OP_HARD_STOP, 1'b0, 8'd255);
        push_cmd(OP_SET_TARGET, 1'b0, 8'd255);  // full backward target
        drain();

        // Random phases, each under its own interval setting.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_interval(PHASE_INTERVAL[p]);
            random_phase(PHASE_ITEMS);
            drain();
        end

        @(negedge clk);
        if (mismatches == 0)
        begin
            $display("[hbridge_speed_ramp] OK");
        end
        else
        begin
            $display("[hbridge_speed_ramp] ERROR");
        end
        $finish;
    end

endmodule
